>>> design/ecsm_pkg.sv
// Shared types and codes for the elliptic-curve scalar multiplier.
package ecsm_pkg;

  // Operations of the shared modular arithmetic unit.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ZERO_K  = 2'd1;
  localparam logic [1:0] STATUS_NO_INV  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_CURVE_A = 1'b0;
  localparam logic REG_PRIME   = 1'b1;

endpackage

>>> design/ecsm_alu.sv
// Shared modular arithmetic unit: add, subtract, bit-serial multiply and divide.
module ecsm_alu
  import ecsm_pkg::*;
#(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  alu_req_t     req_i,
  input  logic [W-1:0] opa_i,
  input  logic [W-1:0] opb_i,
  input  logic [W-1:0] mod_i,
  output logic         done_o,
  output logic [W-1:0] res_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  alu_op_e       op_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  acc_q;
  logic [W-1:0]  opa_q;
  logic [W-1:0]  opb_q;
  logic [W:0]    rem_q;

  logic [W-1:0]  mul_dbl;
  logic [W-1:0]  mul_next;
  logic [W:0]    div_sh;
  logic          div_ge;

  // Modular addition without overflow: both operands lie below the modulus.
  function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] p);
    logic [W-1:0] room;
    room = p - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] p);
    return (x >= y) ? (x - y) : (p - (y - x));
  endfunction

  // One step of the shift-and-add multiplier and of the restoring divider.
  always_comb begin
    mul_dbl  = addm(acc_q, acc_q, mod_i);
    mul_next = opb_q[W-1] ? addm(mul_dbl, opa_q, mod_i) : mul_dbl;
    div_sh   = {rem_q[W-1:0], acc_q[W-1]};
    div_ge   = (div_sh >= {1'b0, opa_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_ADD;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q <= req_i.op;
        case (req_i.op)
          OP_ADD: begin
            acc_q  <= addm(opa_i, opb_i, mod_i);
            done_q <= 1'b1;
          end
          OP_SUB: begin
            acc_q  <= subm(opa_i, opb_i, mod_i);
            done_q <= 1'b1;
          end
          OP_MUL: begin
            acc_q  <= '0;
            opa_q  <= opa_i;
            opb_q  <= opb_i;
            cnt_q  <= CW'(W);
            busy_q <= 1'b1;
          end
          default: begin
            // Dividend shifts through the accumulator, quotient bits enter below.
            acc_q  <= opa_i;
            opa_q  <= opb_i;
            rem_q  <= '0;
            cnt_q  <= CW'(W);
            busy_q <= 1'b1;
          end
        endcase
      end else if (busy_q) begin
        if (op_q == OP_MUL) begin
          acc_q <= mul_next;
          opb_q <= {opb_q[W-2:0], 1'b0};
        end else begin
          rem_q <= div_ge ? (div_sh - {1'b0, opa_q}) : div_sh;
          acc_q <= {acc_q[W-2:0], div_ge};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
  assign rem_o  = rem_q[W-1:0];

endmodule

>>> design/ec_scalar_multiply.sv
// Elliptic-curve scalar multiplier by left-to-right double-and-add over GF(p).
// Steps: division reduces curve_a, x and y; then for each scalar bit below the top one
// a doubling and possibly an addition, each with one inversion by Euclid steps (each a
// division, a multiplication and a subtraction) and up to four modular multiplications.
// One transaction at a time: a new input is taken only in the idle state.
// Reset: asynchronous, active low; curve_a clears to 0 and prime_modulus to 65521.
module ec_scalar_multiply
  import ecsm_pkg::*;
#(
  parameter int FIELD_WIDTH  = 16,
  parameter int SCALAR_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [FIELD_WIDTH-1:0] cfg_data_i,
  // Input stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: point_x, point_y, scalar (lowest first), zero padded to bytes.
  input  logic [((2*FIELD_WIDTH+SCALAR_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // Output stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: result_x, result_y, status (lowest first), zero padded to bytes.
  output logic [((2*FIELD_WIDTH+2+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int W      = FIELD_WIDTH;
  localparam int S      = SCALAR_WIDTH;
  localparam int OUT_W  = ((2*W+2+7)/8)*8;
  localparam int IW     = $clog2(S);
  localparam logic [W-1:0] P_RST = W'(65521);

  typedef enum logic [5:0] {
    S_IDLE, S_RED_A, S_RED_X, S_RED_Y, S_CHECK, S_SCAN, S_NEXT,
    S_DBL_CHK, S_DBL_V, S_DBL_SQ, S_DBL_N2, S_DBL_N3, S_DBL_NA, S_DBL_LAM,
    S_DBL_LL, S_DBL_2X, S_DBL_X3, S_DBL_D, S_DBL_M, S_DBL_Y3,
    S_ADD_CHK, S_ADD_V, S_ADD_DY, S_ADD_LAM, S_ADD_LL, S_ADD_S1, S_ADD_X3,
    S_ADD_D, S_ADD_M, S_ADD_Y3,
    S_INV_CHK, S_INV_DIV, S_INV_MUL, S_INV_SUB, S_OUT
  } state_e;

  state_e          state_q;
  logic            wait_q;
  logic            out_valid_q;
  logic            dbl_from_add_q;
  logic            inv_for_add_q;
  logic [W-1:0]    curve_a_q;
  logic [W-1:0]    prime_q;
  logic [W-1:0]    in_x_q, in_y_q;
  logic [S-1:0]    k_q;
  logic [IW-1:0]   idx_q;
  logic [W-1:0]    a_q, ax_q, ay_q, bx_q, by_q;
  logic [W-1:0]    tmp_q, lam_q, x3_q, inv_q;
  logic [W-1:0]    r0_q, r1_q, r2_q, t0_q, t1_q, q_q;
  logic [W-1:0]    res_x_q, res_y_q;
  logic [1:0]      status_q;

  alu_req_t        alu_req;
  logic            calc;
  logic [W-1:0]    opa, opb;
  logic            alu_done;
  logic [W-1:0]    alu_res, alu_rem;

  ecsm_alu #(.W(W)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (opa),
    .opb_i  (opb),
    .mod_i  (prime_q),
    .done_o (alu_done),
    .res_o  (alu_res),
    .rem_o  (alu_rem)
  );

  // Operand selection for the arithmetic unit in each computing state.
  always_comb begin
    calc       = 1'b1;
    alu_req.op = OP_ADD;
    opa        = '0;
    opb        = '0;
    case (state_q)
      S_RED_A:   begin alu_req.op = OP_DIV; opa = curve_a_q; opb = prime_q; end
      S_RED_X:   begin alu_req.op = OP_DIV; opa = in_x_q;    opb = prime_q; end
      S_RED_Y:   begin alu_req.op = OP_DIV; opa = in_y_q;    opb = prime_q; end
      S_DBL_V:   begin alu_req.op = OP_ADD; opa = ay_q;  opb = ay_q;  end
      S_DBL_SQ:  begin alu_req.op = OP_MUL; opa = ax_q;  opb = ax_q;  end
      S_DBL_N2:  begin alu_req.op = OP_ADD; opa = tmp_q; opb = tmp_q; end
      S_DBL_N3:  begin alu_req.op = OP_ADD; opa = lam_q; opb = tmp_q; end
      S_DBL_NA:  begin alu_req.op = OP_ADD; opa = tmp_q; opb = a_q;   end
      S_DBL_LAM: begin alu_req.op = OP_MUL; opa = tmp_q; opb = inv_q; end
      S_DBL_LL:  begin alu_req.op = OP_MUL; opa = lam_q; opb = lam_q; end
      S_DBL_2X:  begin alu_req.op = OP_ADD; opa = ax_q;  opb = ax_q;  end
      S_DBL_X3:  begin alu_req.op = OP_SUB; opa = tmp_q; opb = x3_q;  end
      S_DBL_D:   begin alu_req.op = OP_SUB; opa = ax_q;  opb = x3_q;  end
      S_DBL_M:   begin alu_req.op = OP_MUL; opa = lam_q; opb = tmp_q; end
      S_DBL_Y3:  begin alu_req.op = OP_SUB; opa = tmp_q; opb = ay_q;  end
      S_ADD_V:   begin alu_req.op = OP_SUB; opa = bx_q;  opb = ax_q;  end
      S_ADD_DY:  begin alu_req.op = OP_SUB; opa = by_q;  opb = ay_q;  end
      S_ADD_LAM: begin alu_req.op = OP_MUL; opa = tmp_q; opb = inv_q; end
      S_ADD_LL:  begin alu_req.op = OP_MUL; opa = lam_q; opb = lam_q; end
      S_ADD_S1:  begin alu_req.op = OP_SUB; opa = tmp_q; opb = ax_q;  end
      S_ADD_X3:  begin alu_req.op = OP_SUB; opa = tmp_q; opb = bx_q;  end
      S_ADD_D:   begin alu_req.op = OP_SUB; opa = ax_q;  opb = x3_q;  end
      S_ADD_M:   begin alu_req.op = OP_MUL; opa = lam_q; opb = tmp_q; end
      S_ADD_Y3:  begin alu_req.op = OP_SUB; opa = tmp_q; opb = ay_q;  end
      S_INV_DIV: begin alu_req.op = OP_DIV; opa = r0_q;  opb = r1_q;  end
      S_INV_MUL: begin alu_req.op = OP_MUL; opa = q_q;   opb = t1_q;  end
      S_INV_SUB: begin alu_req.op = OP_SUB; opa = t0_q;  opb = q_q;   end
      default:   calc = 1'b0;
    endcase
    alu_req.start = calc && !wait_q;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_a_q <= '0;
      prime_q   <= P_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CURVE_A: curve_a_q <= cfg_data_i;
        REG_PRIME:   prime_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Sequencer: input reduction, bit scan, doubling, addition and inversion.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      wait_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      dbl_from_add_q <= 1'b0;
      inv_for_add_q  <= 1'b0;
    end else begin
      if (alu_req.start) wait_q <= 1'b1;
      if (calc && wait_q && alu_done) wait_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            in_x_q <= s_axis_tdata_i[W-1:0];
            in_y_q <= s_axis_tdata_i[2*W-1:W];
            k_q    <= s_axis_tdata_i[2*W+S-1:2*W];
            if (prime_q < W'(3)) begin
              res_x_q     <= '0;
              res_y_q     <= '0;
              status_q    <= STATUS_NO_INV;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end else begin
              state_q <= S_RED_A;
            end
          end
        end
        S_RED_A: if (wait_q && alu_done) begin a_q  <= alu_rem; state_q <= S_RED_X; end
        S_RED_X: if (wait_q && alu_done) begin bx_q <= alu_rem; state_q <= S_RED_Y; end
        S_RED_Y: if (wait_q && alu_done) begin by_q <= alu_rem; state_q <= S_CHECK; end
        S_CHECK: begin
          res_x_q <= '0;
          res_y_q <= '0;
          if (bx_q == '0 && by_q == '0) begin
            status_q    <= STATUS_OK;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else if (k_q == '0) begin
            status_q    <= STATUS_ZERO_K;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            ax_q    <= bx_q;
            ay_q    <= by_q;
            idx_q   <= IW'(S - 1);
            state_q <= S_SCAN;
          end
        end
        // Find the top set bit of the scalar.
        S_SCAN: begin
          if (k_q[idx_q]) state_q <= S_NEXT;
          else            idx_q   <= idx_q - 1'b1;
        end
        S_NEXT: begin
          if (idx_q == '0) begin
            res_x_q     <= ax_q;
            res_y_q     <= ay_q;
            status_q    <= STATUS_OK;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= S_DBL_CHK;
          end
        end
        // Doubling; a point with y of zero doubles to infinity.
        S_DBL_CHK: begin
          if (ay_q == '0) begin
            ax_q           <= '0;
            ay_q           <= '0;
            dbl_from_add_q <= 1'b0;
            state_q        <= dbl_from_add_q ? S_NEXT : S_ADD_CHK;
          end else begin
            state_q <= S_DBL_V;
          end
        end
        S_DBL_V: if (wait_q && alu_done) begin
          r0_q          <= prime_q;
          r1_q          <= alu_res;
          t0_q          <= '0;
          t1_q          <= W'(1);
          inv_for_add_q <= 1'b0;
          state_q       <= S_INV_CHK;
        end
        S_DBL_SQ:  if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_DBL_N2;  end
        S_DBL_N2:  if (wait_q && alu_done) begin lam_q <= alu_res; state_q <= S_DBL_N3;  end
        S_DBL_N3:  if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_DBL_NA;  end
        S_DBL_NA:  if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_DBL_LAM; end
        S_DBL_LAM: if (wait_q && alu_done) begin lam_q <= alu_res; state_q <= S_DBL_LL;  end
        S_DBL_LL:  if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_DBL_2X;  end
        S_DBL_2X:  if (wait_q && alu_done) begin x3_q  <= alu_res; state_q <= S_DBL_X3;  end
        S_DBL_X3:  if (wait_q && alu_done) begin x3_q  <= alu_res; state_q <= S_DBL_D;   end
        S_DBL_D:   if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_DBL_M;   end
        S_DBL_M:   if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_DBL_Y3;  end
        S_DBL_Y3: if (wait_q && alu_done) begin
          ax_q           <= x3_q;
          ay_q           <= alu_res;
          dbl_from_add_q <= 1'b0;
          state_q        <= dbl_from_add_q ? S_NEXT : S_ADD_CHK;
        end
        // Addition of the base point when the current scalar bit is set.
        S_ADD_CHK: begin
          if (!k_q[idx_q]) begin
            state_q <= S_NEXT;
          end else if (ax_q == '0 && ay_q == '0) begin
            ax_q    <= bx_q;
            ay_q    <= by_q;
            state_q <= S_NEXT;
          end else if (ax_q == bx_q) begin
            if (ay_q == by_q) begin
              dbl_from_add_q <= 1'b1;
              state_q        <= S_DBL_CHK;
            end else begin
              ax_q    <= '0;
              ay_q    <= '0;
              state_q <= S_NEXT;
            end
          end else begin
            state_q <= S_ADD_V;
          end
        end
        S_ADD_V: if (wait_q && alu_done) begin
          r0_q          <= prime_q;
          r1_q          <= alu_res;
          t0_q          <= '0;
          t1_q          <= W'(1);
          inv_for_add_q <= 1'b1;
          state_q       <= S_INV_CHK;
        end
        S_ADD_DY:  if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_ADD_LAM; end
        S_ADD_LAM: if (wait_q && alu_done) begin lam_q <= alu_res; state_q <= S_ADD_LL;  end
        S_ADD_LL:  if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_ADD_S1;  end
        S_ADD_S1:  if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_ADD_X3;  end
        S_ADD_X3:  if (wait_q && alu_done) begin x3_q  <= alu_res; state_q <= S_ADD_D;   end
        S_ADD_D:   if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_ADD_M;   end
        S_ADD_M:   if (wait_q && alu_done) begin tmp_q <= alu_res; state_q <= S_ADD_Y3;  end
        S_ADD_Y3: if (wait_q && alu_done) begin
          ax_q    <= x3_q;
          ay_q    <= alu_res;
          state_q <= S_NEXT;
        end
        // Extended Euclid; a final remainder other than one means no inverse.
        S_INV_CHK: begin
          if (r1_q == '0) begin
            if (r0_q != W'(1)) begin
              res_x_q     <= '0;
              res_y_q     <= '0;
              status_q    <= STATUS_NO_INV;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end else begin
              inv_q   <= t0_q;
              state_q <= inv_for_add_q ? S_ADD_DY : S_DBL_SQ;
            end
          end else begin
            state_q <= S_INV_DIV;
          end
        end
        S_INV_DIV: if (wait_q && alu_done) begin
          q_q     <= (alu_res >= prime_q) ? (alu_res - prime_q) : alu_res;
          r2_q    <= alu_rem;
          state_q <= S_INV_MUL;
        end
        S_INV_MUL: if (wait_q && alu_done) begin q_q <= alu_res; state_q <= S_INV_SUB; end
        S_INV_SUB: if (wait_q && alu_done) begin
          r0_q    <= r1_q;
          r1_q    <= r2_q;
          t0_q    <= t1_q;
          t1_q    <= alu_res;
          state_q <= S_INV_CHK;
        end
        S_OUT: begin
          if (m_axis_tready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({status_q, res_y_q, res_x_q});

endmodule
